>>> src/htirq_pkg.sv
// htirq_pkg: shared types and constants of the handheld timer / irq register block
// item structs, opcode codes, special register offsets and default sizes
// no dependencies
package htirq_pkg;

   localparam int unsigned REG_COUNT_DEFAULT = 64;
   localparam int unsigned TIMER_WIDTH       = 23;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_READ  = 3'd1,
      OP_WRITE = 3'd2,
      OP_DMA   = 3'd3,
      OP_FRAME = 3'd4
   } htirq_op_type;

   localparam logic [5:0] ADDR_JOYPAD = 6'h20;
   localparam logic [5:0] ADDR_PORT21 = 6'h21;
   localparam logic [5:0] ADDR_PORT22 = 6'h22;
   localparam logic [5:0] ADDR_TIMER  = 6'h23;
   localparam logic [5:0] ADDR_TACK   = 6'h24;
   localparam logic [5:0] ADDR_DACK   = 6'h25;
   localparam logic [5:0] ADDR_BANK   = 6'h26;
   localparam logic [5:0] ADDR_STATUS = 6'h27;

   localparam logic [8:0] TIMER_ZERO_LOAD = 9'h100;

   typedef struct packed {
      logic [2:0] opcode;
      logic [5:0] reg_addr;
      logic [7:0] write_data;
      logic [7:0] joypad;
   } htirq_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_level;
      logic       nmi_pulse;
      logic [2:0] rom_bank;
   } htirq_rsp_type;

   typedef struct packed {
      logic       is_read;
      logic       hit;
      logic [5:0] reg_addr;
      logic [7:0] joypad;
      logic [3:0] nib22;
      logic       timer_flag;
      logic       dma_flag;
      logic       irq_level;
      logic       nmi_pulse;
      logic [2:0] rom_bank;
   } htirq_stage_type;

endpackage

>>> src/htirq_ram.sv
// htirq_ram: generic single write port, single read port ram with registered read
// read data holds while read enable is low
// no dependencies
module htirq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/handheld_timer_irq_registers_core.sv
// handheld_timer_irq_registers_core: system register block top level
// register file in htirq_ram, timer, flags, irq/nmi and bank select; uses htirq_pkg
//
// One item is taken every clock cycle (tick, read, write, dma done or frame start) while
// the read stage is not stalled by a waiting result, and one result comes back per item.
// Results pass the registered read of the register file ram, then the output register;
// timer, flags and the shadow copies of offsets 0x22 and 0x26 live in flip-flops and
// are updated in the accept cycle. Reset clears a per-entry valid vector, so unwritten
// entries read as zero with no clearing pass. An output register and one pipeline stage
// let a new item enter while a finished result waits to be taken.
module handheld_timer_irq_registers_core
   import htirq_pkg::*;
#(
   parameter int unsigned REG_COUNT = REG_COUNT_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  htirq_req_type req_item,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output htirq_rsp_type rsp_item
);

   localparam int unsigned AW        = $clog2(REG_COUNT);
   localparam logic [8:0]  REG_LIMIT = 9'(REG_COUNT);

   logic                   req_fire;
   logic                   out_free;
   logic                   in_range;
   logic [AW-1:0]          reg_idx;
   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [7:0]             ram_q;

   logic [REG_COUNT-1:0]   valid_ff, valid_in;
   logic [TIMER_WIDTH-1:0] timer_count_ff, timer_count_in;
   logic [TIMER_WIDTH-1:0] timer_dec;
   logic                   timer_running_ff, timer_running_in;
   logic                   timer_flag_ff, timer_flag_in;
   logic                   dma_flag_ff, dma_flag_in;
   logic [7:0]             bank_ff, bank_in;
   logic [3:0]             nib22_ff, nib22_in;
   logic [8:0]             load_n;
   logic                   nmi;

   logic                   s1_valid_ff, s1_valid_in;
   htirq_stage_type        s1_ff, s1_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   htirq_rsp_type          rsp_item_ff, rsp_item_in;
   logic [7:0]             stored;
   logic [7:0]             rdata;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;
   assign in_range  = {3'b000, req_item.reg_addr} < REG_LIMIT;
   assign reg_idx   = AW'({3'b000, req_item.reg_addr});
   assign ram_wr_en = req_fire && (req_item.opcode == OP_WRITE) && in_range;
   assign ram_rd_en = req_fire && (req_item.opcode == OP_READ) && in_range;
   assign timer_dec = (timer_count_ff != '0) ? timer_count_ff - 1'b1 : timer_count_ff;
   assign load_n    = (req_item.write_data == 8'h00) ? TIMER_ZERO_LOAD
                                                     : {1'b0, req_item.write_data};

   htirq_ram #(
      .WIDTH (8),
      .DEPTH (REG_COUNT)
   ) u_regs (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (reg_idx),
      .wr_data (req_item.write_data),
      .rd_en   (ram_rd_en),
      .rd_addr (reg_idx),
      .rd_data (ram_q)
   );

   // accept stage: state update
   always_comb begin
      valid_in         = valid_ff;
      timer_count_in   = timer_count_ff;
      timer_running_in = timer_running_ff;
      timer_flag_in    = timer_flag_ff;
      dma_flag_in      = dma_flag_ff;
      bank_in          = bank_ff;
      nib22_in         = nib22_ff;
      nmi              = 1'b0;
      if (req_fire) begin
         unique case (req_item.opcode)
            OP_TICK: begin
               if (timer_running_ff) begin
                  timer_count_in = timer_dec;
                  if (timer_dec == '0) begin
                     timer_flag_in    = 1'b1;
                     timer_running_in = 1'b0;
                  end
               end
            end
            OP_READ: begin
               if (req_item.reg_addr == ADDR_TACK) begin
                  timer_flag_in = 1'b0;
               end
               if (req_item.reg_addr == ADDR_DACK) begin
                  dma_flag_in = 1'b0;
               end
            end
            OP_WRITE: begin
               if (in_range) begin
                  valid_in[reg_idx] = 1'b1;
                  if (req_item.reg_addr == ADDR_TIMER) begin
                     timer_count_in   = bank_ff[4] ? {load_n, 14'd0}
                                                   : {6'd0, load_n, 8'd0};
                     timer_running_in = 1'b1;
                  end
                  if (req_item.reg_addr == ADDR_BANK) begin
                     bank_in = req_item.write_data;
                  end
                  if (req_item.reg_addr == ADDR_PORT22) begin
                     nib22_in = req_item.write_data[3:0];
                  end
               end
            end
            OP_DMA: begin
               dma_flag_in = 1'b1;
            end
            OP_FRAME: begin
               nmi = bank_ff[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_in.is_read    = req_item.opcode == OP_READ;
      s1_in.hit        = in_range && valid_ff[reg_idx];
      s1_in.reg_addr   = req_item.reg_addr;
      s1_in.joypad     = req_item.joypad;
      s1_in.nib22      = nib22_ff;
      s1_in.timer_flag = timer_flag_in;
      s1_in.dma_flag   = dma_flag_in;
      s1_in.irq_level  = (timer_flag_in && bank_in[1]) || (dma_flag_in && bank_in[2]);
      s1_in.nmi_pulse  = nmi;
      s1_in.rom_bank   = bank_in[7:5];
      s1_valid_in      = req_fire ? 1'b1 : (out_free ? 1'b0 : s1_valid_ff);
   end

   // read stage: merge ram data with special registers
   always_comb begin
      stored = s1_ff.hit ? ram_q : 8'h00;
      unique case (s1_ff.reg_addr)
         ADDR_JOYPAD: rdata = s1_ff.joypad;
         ADDR_PORT21: rdata = {stored[7:4], s1_ff.nib22};
         ADDR_STATUS: rdata = {stored[7:2], s1_ff.dma_flag, s1_ff.timer_flag};
         default:     rdata = stored;
      endcase
      rsp_item_in.read_data = s1_ff.is_read ? rdata : 8'h00;
      rsp_item_in.irq_level = s1_ff.irq_level;
      rsp_item_in.nmi_pulse = s1_ff.nmi_pulse;
      rsp_item_in.rom_bank  = s1_ff.rom_bank;
      rsp_valid_in = (s1_valid_ff && out_free) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff         <= '0;
         timer_count_ff   <= '0;
         timer_running_ff <= 1'b0;
         timer_flag_ff    <= 1'b0;
         dma_flag_ff      <= 1'b0;
         bank_ff          <= 8'h00;
         nib22_ff         <= 4'h0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         valid_ff         <= valid_in;
         timer_count_ff   <= timer_count_in;
         timer_running_ff <= timer_running_in;
         timer_flag_ff    <= timer_flag_in;
         dma_flag_ff      <= dma_flag_in;
         bank_ff          <= bank_in;
         nib22_ff         <= nib22_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
      if (s1_valid_ff && out_free) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_running_nonzero: assert property (@(posedge clock) disable iff (reset)
      timer_running_ff |-> (timer_count_ff != '0))
      else $error("timer running with zero count");

   a_expiry_sets_flag: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_item.opcode == OP_TICK) && timer_running_ff &&
       (timer_count_ff == TIMER_WIDTH'(1)))
      |=> (timer_flag_ff && !timer_running_ff))
      else $error("timer expiry did not set flag and stop");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted item missing from read stage");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("read stage changed while stalled");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |-> !req_ready)
      else $error("input taken while read stage stalled");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for handheld_timer_irq_registers_core
// keeps its own register file, timer and flag model and checks every result item
// depends on htirq_pkg and the core under src

module testbench;
   import htirq_pkg::*;

   localparam int unsigned RESET_CYCLES  = 12;
   localparam int unsigned RANDOM_ITEMS  = 550;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int          TIMEOUT_NS    = 5_000_000;

   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   localparam int BANK_NMI_EN       = 0;
   localparam int BANK_TIMER_IRQ_EN = 1;
   localparam int BANK_DMA_IRQ_EN   = 2;
   localparam int BANK_TIMER_SLOW   = 4;
   localparam int TIMER_FAST_SHIFT  = 8;
   localparam int TIMER_SLOW_SHIFT  = 14;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   htirq_req_type req_item  = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   htirq_rsp_type rsp_item;

   logic [7:0]             model_regs [REG_COUNT_DEFAULT];
   logic [TIMER_WIDTH-1:0] model_count;
   logic                   model_running;
   logic                   model_tflag;
   logic                   model_dflag;

   htirq_rsp_type pending_results [$];
   int unsigned   items_sent    = 0;
   int unsigned   results_seen  = 0;
   int unsigned   error_count   = 0;
   bit            no_idle       = 1'b0;

   handheld_timer_irq_registers_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAIL handheld_timer_irq_registers_core");
      $finish;
   end

   task automatic clear_model();
      foreach (model_regs[i]) model_regs[i] = '0;
      model_count   = '0;
      model_running = 1'b0;
      model_tflag   = 1'b0;
      model_dflag   = 1'b0;
   endtask

   task automatic predict_register_step(input htirq_req_type item,
                                        output htirq_rsp_type result);
      logic [7:0]             rdata;
      logic                   nmi;
      logic [7:0]             bank;
      logic [8:0]             load_n;
      logic [TIMER_WIDTH-1:0] load;
      rdata = '0;
      nmi   = 1'b0;
      case (item.opcode)
         OP_TICK: begin
            if (model_running) begin
               if (model_count != '0) model_count = model_count - 1'b1;
               if (model_count == '0) begin
                  model_tflag   = 1'b1;
                  model_running = 1'b0;
               end
            end
         end
         OP_READ: begin
            rdata = model_regs[item.reg_addr];
            case (item.reg_addr)
               ADDR_JOYPAD: rdata = item.joypad;
               ADDR_PORT21: rdata = {rdata[7:4], model_regs[ADDR_PORT22][3:0]};
               ADDR_TACK:   model_tflag = 1'b0;
               ADDR_DACK:   model_dflag = 1'b0;
               ADDR_STATUS: rdata = {rdata[7:2], model_dflag, model_tflag};
               default: ;
            endcase
         end
         OP_WRITE: begin
            model_regs[item.reg_addr] = item.write_data;
            if (item.reg_addr == ADDR_TIMER) begin
               load_n = (item.write_data == '0) ? TIMER_ZERO_LOAD : {1'b0, item.write_data};
               load   = TIMER_WIDTH'(load_n);
               if (model_regs[ADDR_BANK][BANK_TIMER_SLOW]) load = load << TIMER_SLOW_SHIFT;
               else load = load << TIMER_FAST_SHIFT;
               model_count   = load;
               model_running = 1'b1;
            end
         end
         OP_DMA:   model_dflag = 1'b1;
         OP_FRAME: nmi = model_regs[ADDR_BANK][BANK_NMI_EN];
         default: ;
      endcase
      bank = model_regs[ADDR_BANK];
      result.read_data = rdata;
      result.irq_level = (model_tflag && bank[BANK_TIMER_IRQ_EN]) ||
                         (model_dflag && bank[BANK_DMA_IRQ_EN]);
      result.nmi_pulse = nmi;
      result.rom_bank  = bank[7:5];
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : scoreboard
      htirq_rsp_type predicted;
      htirq_rsp_type oldest;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_register_step(req_item, predicted);
            pending_results.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               $display("%0t: result item with none expected, expected none actual %0h",
                        $time, rsp_item);
               error_count++;
            end else begin
               oldest = pending_results.pop_front();
               check_field("read_data", oldest.read_data, rsp_item.read_data);
               check_field("irq_level", 8'(oldest.irq_level), 8'(rsp_item.irq_level));
               check_field("nmi_pulse", 8'(oldest.nmi_pulse), 8'(rsp_item.nmi_pulse));
               check_field("rom_bank", 8'(oldest.rom_bank), 8'(rsp_item.rom_bank));
            end
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   initial begin
      int unsigned gap;
      while (reset) @(posedge clock);
      forever begin
         gap = pick_gap();
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   task automatic send_item(input htirq_req_type item);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic issue(input logic [2:0] op, input logic [5:0] addr, input logic [7:0] data);
      htirq_req_type item;
      item.opcode     = op;
      item.reg_addr   = addr;
      item.write_data = data;
      item.joypad     = 8'($urandom);
      send_item(item);
   endtask

   task automatic issue_ticks(input int unsigned count);
      repeat (count) issue(OP_TICK, 6'($urandom), 8'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (results_seen < items_sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic htirq_req_type random_item();
      htirq_req_type item;
      int unsigned   roll;
      roll            = $urandom_range(0, 99);
      item.joypad     = 8'($urandom);
      item.write_data = 8'($urandom);
      item.reg_addr   = $urandom_range(0, 1) ? 6'(ADDR_JOYPAD + $urandom_range(0, 7))
                                             : 6'($urandom_range(0, REG_COUNT_DEFAULT - 1));
      if (roll < 35)      item.opcode = OP_TICK;
      else if (roll < 60) item.opcode = OP_READ;
      else if (roll < 80) item.opcode = OP_WRITE;
      else if (roll < 88) item.opcode = OP_DMA;
      else if (roll < 95) item.opcode = OP_FRAME;
      else item.opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      return item;
   endfunction

   task automatic test_reset_state();
      issue(OP_READ, ADDR_STATUS, '0);
      issue(OP_READ, '0, '0);
      issue(OP_READ, 6'h3f, '0);
   endtask

   task automatic test_register_access();
      htirq_req_type item;
      issue(OP_WRITE, '0, 8'hff);
      issue(OP_READ, '0, '0);
      issue(OP_WRITE, 6'h3f, 8'hff);
      issue(OP_READ, 6'h3f, '0);
      issue(OP_WRITE, ADDR_PORT21, 8'ha5);
      issue(OP_WRITE, ADDR_PORT22, 8'h5a);
      issue(OP_READ, ADDR_PORT21, '0);
      item = '0;
      item.opcode   = OP_READ;
      item.reg_addr = ADDR_JOYPAD;
      send_item(item);
      item.joypad = 8'hff;
      send_item(item);
   endtask

   task automatic test_flags_and_irq();
      issue(OP_WRITE, ADDR_BANK, 8'he7);
      issue(OP_DMA, '0, '0);
      issue(OP_READ, ADDR_STATUS, '0);
      issue(OP_READ, ADDR_DACK, '0);
      issue(OP_FRAME, '0, '0);
      issue(OP_WRITE, ADDR_BANK, 8'h00);
      issue(OP_FRAME, '0, '0);
   endtask

   task automatic test_spare_opcodes();
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
         issue(3'(op), 6'($urandom), 8'($urandom));
      end
   endtask

   task automatic test_timer_fast();
      issue(OP_WRITE, ADDR_BANK, 8'h02);
      issue_ticks(2);
      issue(OP_WRITE, ADDR_TIMER, 8'h01);
      issue_ticks(255);
      issue(OP_READ, ADDR_STATUS, '0);
      issue_ticks(2);
      issue(OP_READ, ADDR_STATUS, '0);
      issue(OP_READ, ADDR_TACK, '0);
      // reload while still counting
      issue(OP_WRITE, ADDR_TIMER, 8'h02);
      issue_ticks(100);
      issue(OP_WRITE, ADDR_TIMER, 8'h01);
      issue_ticks(257);
      issue(OP_READ, ADDR_TACK, '0);
   endtask

   task automatic test_timer_zero_value();
      no_idle = 1'b1;
      issue(OP_WRITE, ADDR_TIMER, 8'h00);
      issue_ticks(260);
      no_idle = 1'b0;
      issue(OP_READ, ADDR_STATUS, '0);
   endtask

   task automatic test_timer_slow_scale();
      no_idle = 1'b1;
      issue(OP_WRITE, ADDR_BANK, 8'h12);
      issue(OP_WRITE, ADDR_TIMER, 8'h01);
      issue_ticks(260);
      no_idle = 1'b0;
      issue(OP_READ, ADDR_TACK, '0);
      issue(OP_WRITE, ADDR_BANK, 8'h00);
   endtask

   task automatic run_timer_burst();
      logic [7:0] bank;
      bank = 8'($urandom);
      bank[BANK_TIMER_SLOW] = 1'b0;
      issue(OP_WRITE, ADDR_BANK, bank);
      issue(OP_WRITE, ADDR_TIMER, 8'($urandom_range(1, 2)));
      repeat ($urandom_range(300, 560)) begin
         if ($urandom_range(0, 99) < 85) issue(OP_TICK, 6'($urandom), 8'($urandom));
         else send_item(random_item());
      end
   endtask

   task automatic test_random_traffic();
      int unsigned start;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0) run_timer_burst();
         else repeat ($urandom_range(40, 120)) send_item(random_item());
         if ($urandom_range(0, 9) == 0) wait_drained();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      clear_model();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_register_access();
      test_flags_and_irq();
      wait_drained();
      test_spare_opcodes();
      test_timer_fast();
      test_timer_zero_value();
      test_timer_slow_scale();
      wait_drained();
      test_random_traffic();
      wait_drained();
      if (pending_results.size() != 0) begin
         $display("%0t: results left over, expected 0 actual %0d", $time,
                  pending_results.size());
         error_count++;
      end
      if (error_count == 0) $display("PASS handheld_timer_irq_registers_core");
      else $display("FAIL handheld_timer_irq_registers_core");
      $finish;
   end

endmodule
